// ----- design/frd_pkg.sv -----
// ----------------------------------------------------------------------------
// frd_pkg: shared constants and types for the fragment reassembly deframer
// Holds sizes, status and opcode codes, the controller command struct, and
// the CRC-16 byte update.
// ----------------------------------------------------------------------------
package frd_pkg;

  localparam int FRAME_BUF_BYTES  = 2048;
  localparam int MAX_FRAGMENTS    = 16;
  localparam int MAX_PACKET_BYTES = 255;

  localparam int BUF_AW   = $clog2(FRAME_BUF_BYTES);
  localparam int LEN_W    = BUF_AW + 1;
  localparam int STAGE_AW = 8;
  localparam int HDR_LEN  = 11;
  localparam int OVERHEAD = 13;
  localparam int CNT_W    = 9;
  localparam int CNT_SAT  = 511;

  localparam logic [2:0] ST_PENDING   = 3'd0;
  localparam logic [2:0] ST_COMPLETE  = 3'd1;
  localparam logic [2:0] ST_SIZE      = 3'd2;
  localparam logic [2:0] ST_IDENTITY  = 3'd3;
  localparam logic [2:0] ST_CHECKSUM  = 3'd4;
  localparam logic [2:0] ST_DUPLICATE = 3'd5;
  localparam logic [2:0] ST_READ      = 3'd6;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] REG_MAX_PAYLOAD = 2'd0;
  localparam logic [1:0] REG_MAGIC       = 2'd1;
  localparam logic [1:0] REG_VERSION     = 2'd2;
  localparam logic [1:0] REG_TYPE        = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_byte;   // absorb data_byte into header, stage and CRC
    logic check;       // evaluate the finished packet
    logic copy;        // move one staged byte into the frame buffer
    logic read;        // issue a frame buffer read
    logic finish;      // emit the packet verdict
    logic emit_read;   // emit the read result
  } frd_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic commit;      // checked packet is to be committed
    logic copy_done;   // last staged byte is being copied
  } frd_stat_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ----- design/frd_ctrl.sv -----
// ----------------------------------------------------------------------------
// frd_ctrl: sequencing controller
// Accepts one command word at a time and steps the datapath through byte
// intake, packet check, payload copy and buffer read.
// ----------------------------------------------------------------------------
module frd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               opcode,
  input  logic               last_byte,
  input  frd_pkg::frd_stat_t stat,
  output logic               busy,
  output frd_pkg::frd_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_COPY  = 3'd2;
  localparam logic [2:0] S_DONE  = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_RDOUT = 3'd5;

  logic [2:0] state, state_next;
  logic       accept;

  assign accept = start && (state == S_IDLE);
  assign busy   = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (opcode == frd_pkg::OP_READ) begin
            cmd.read   = 1'b1;
            state_next = S_RDOUT;
          end else begin
            cmd.take_byte = 1'b1;
            if (last_byte) state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = S_COPY;
      end
      S_COPY: begin
        if (stat.commit && !stat.copy_done) begin
          cmd.copy = 1'b1;
        end else begin
          if (stat.commit) cmd.copy = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      S_READ: state_next = S_RDOUT;
      S_RDOUT: begin
        cmd.emit_read = 1'b1;
        state_next    = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assert property (@(posedge clk) disable iff (rst) accept |=> !busy || $past(opcode) ||
                   $past(last_byte))
    else $error("busy after a plain packet byte");
  assert property (@(posedge clk) disable iff (rst) cmd.finish |=> !busy)
    else $error("controller did not return to idle after a verdict");
  assert property (@(posedge clk) disable iff (rst) !(cmd.finish && cmd.emit_read))
    else $error("two results in one cycle");

endmodule

// ----- design/frd_datapath.sv -----
// ----------------------------------------------------------------------------
// frd_datapath: header, CRC, staging and frame buffer datapath
// Keeps the packet under reception, checks it, tracks the frame, and copies
// staged payload into the frame buffer one byte per cycle.
// ----------------------------------------------------------------------------
module frd_datapath (
  input  logic               clk,
  input  logic               rst,
  input  frd_pkg::frd_cmd_t  cmd,
  output frd_pkg::frd_stat_t stat,
  input  logic [7:0]         data_byte,
  input  logic [10:0]        read_address,
  input  logic [7:0]         max_radio_payload,
  input  logic [15:0]        expected_magic,
  input  logic [7:0]         expected_version,
  input  logic [7:0]         expected_packet_type,
  output logic               done,
  output logic [2:0]         status,
  output logic [7:0]         frame_stream,
  output logic [15:0]        frame_sequence,
  output logic [11:0]        frame_length,
  output logic [7:0]         read_data
);

  localparam int BW = frd_pkg::BUF_AW;

  logic [7:0]  hdr [frd_pkg::HDR_LEN];
  logic [7:0]  stage_mem [frd_pkg::MAX_PACKET_BYTES];
  logic [7:0]  frame_mem [frd_pkg::FRAME_BUF_BYTES];
  logic [frd_pkg::CNT_W-1:0] pcount;
  logic [15:0] crc, tail;
  logic        active;
  logic [7:0]  cur_stream, cur_count;
  logic [15:0] cur_seq;
  logic [frd_pkg::MAX_FRAGMENTS-1:0] rmask;
  logic [11:0] alen;

  logic [frd_pkg::CNT_W-1:0] plen_cnt;
  logic [15:0] crc_fin, tail_fin;
  logic [2:0]  verdict;
  logic        commit;
  logic [7:0]  copy_len, copy_idx, stage_q;
  logic [BW-1:0] copy_off;
  logic        copy_wr;
  logic [BW-1:0] wr_addr;
  logic [7:0]  rd_q;
  logic        rd_valid;

  // Packet byte intake.
  logic [frd_pkg::CNT_W-1:0] pos;
  assign pos = pcount;

  always_ff @(posedge clk) begin
    if (rst) begin
      pcount <= '0;
      crc    <= 16'hFFFF;
      tail   <= '0;
      for (int i = 0; i < frd_pkg::HDR_LEN; i++) hdr[i] <= '0;
    end else if (cmd.take_byte) begin
      if (pos < frd_pkg::CNT_W'(frd_pkg::HDR_LEN)) hdr[pos[3:0]] <= data_byte;
      if (pos >= 9'd2) crc <= frd_pkg::crc_byte(crc, tail[15:8]);
      tail <= {tail[7:0], data_byte};
      if (pcount != 9'(frd_pkg::CNT_SAT)) pcount <= pcount + 9'd1;
    end else if (cmd.check) begin
      pcount <= '0;
      crc    <= 16'hFFFF;
      tail   <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte && pos >= 9'd11 && pos < 9'd266)
      stage_mem[8'(pos - 9'd11)] <= data_byte;
  end

  // Values seen by the check step.
  assign plen_cnt = pcount;
  assign crc_fin  = crc;
  assign tail_fin = tail;

  logic [7:0]  h_idx, h_cnt, h_plen, h_sum;
  logic [15:0] h_seq;
  logic [7:0]  lim;
  logic [11:0] off_w, end_w;
  logic        restart;
  logic [frd_pkg::MAX_FRAGMENTS-1:0] bitm, mask_base, full;
  always_comb begin
    h_idx  = hdr[7];
    h_cnt  = hdr[8];
    h_plen = hdr[9];
    h_seq  = {hdr[5], hdr[6]};
    h_sum  = '0;
    for (int i = 0; i < 10; i++) h_sum = h_sum + hdr[i];
    if (max_radio_payload <= 8'd13) lim = '0;
    else                            lim = max_radio_payload - 8'd13;
    off_w = 12'(h_idx[3:0] * lim);
    end_w = off_w + 12'(h_plen);
    restart = !active || cur_stream != hdr[4] || cur_seq != h_seq || cur_count != h_cnt;
    bitm = '0;
    bitm[h_idx[3:0]] = 1'b1;
    mask_base = restart ? '0 : rmask;
    full = '0;
    for (int i = 0; i < frd_pkg::MAX_FRAGMENTS; i++)
      full[i] = (i < h_cnt);
    verdict = frd_pkg::ST_PENDING;
    if (plen_cnt < 9'd14 || plen_cnt > 9'(frd_pkg::MAX_PACKET_BYTES))
      verdict = frd_pkg::ST_SIZE;
    else if ({hdr[0], hdr[1]} != expected_magic || hdr[2] != expected_version ||
             hdr[3] != expected_packet_type)
      verdict = frd_pkg::ST_IDENTITY;
    else if (h_cnt == 8'd0 || h_cnt > 8'(frd_pkg::MAX_FRAGMENTS) || h_idx >= h_cnt)
      verdict = frd_pkg::ST_SIZE;
    else if (9'(h_plen) != plen_cnt - 9'd13)
      verdict = frd_pkg::ST_SIZE;
    else if (h_sum != hdr[10] || crc_fin != tail_fin)
      verdict = frd_pkg::ST_CHECKSUM;
    else if ((mask_base & bitm) != '0)
      verdict = frd_pkg::ST_DUPLICATE;
    else if (end_w > 12'(frd_pkg::FRAME_BUF_BYTES))
      verdict = frd_pkg::ST_SIZE;
    else if (((mask_base | bitm) & full) == full)
      verdict = frd_pkg::ST_COMPLETE;
  end

  // Frame tracking, updated on the check step.
  logic [2:0] verdict_q;
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0; cur_stream <= '0; cur_seq <= '0; cur_count <= '0;
      rmask <= '0; alen <= '0; commit <= 1'b0; verdict_q <= frd_pkg::ST_PENDING;
    end else if (cmd.check) begin
      verdict_q <= verdict;
      commit    <= 1'b0;
      if (verdict == frd_pkg::ST_PENDING || verdict == frd_pkg::ST_COMPLETE ||
          verdict == frd_pkg::ST_DUPLICATE || (verdict == frd_pkg::ST_SIZE &&
          plen_cnt >= 9'd14 && plen_cnt <= 9'(frd_pkg::MAX_PACKET_BYTES) &&
          {hdr[0], hdr[1]} == expected_magic && hdr[2] == expected_version &&
          hdr[3] == expected_packet_type && h_cnt != 8'd0 && h_idx < h_cnt &&
          h_cnt <= 8'(frd_pkg::MAX_FRAGMENTS) && 9'(h_plen) == plen_cnt - 9'd13 &&
          h_sum == hdr[10] && crc_fin == tail_fin)) begin
        // Packet passed header and CRC: frame is tracked.
        if (restart) begin
          active <= 1'b1; cur_stream <= hdr[4]; cur_seq <= h_seq; cur_count <= h_cnt;
          rmask <= '0; alen <= '0;
        end
        if (verdict == frd_pkg::ST_SIZE) begin
          active <= 1'b0; cur_stream <= '0; cur_seq <= '0; cur_count <= '0;
          rmask <= '0; alen <= '0;
        end else if (verdict != frd_pkg::ST_DUPLICATE) begin
          commit <= (h_plen != 8'd0);
          rmask  <= mask_base | bitm;
          if (end_w > (restart ? 12'd0 : alen)) alen <= end_w;
          if (verdict == frd_pkg::ST_COMPLETE) active <= 1'b0;
        end
      end
      copy_len <= h_plen;
      copy_off <= BW'(off_w);
      copy_idx <= '0;
    end else if (cmd.copy) begin
      copy_idx <= copy_idx + 8'd1;
      if (stat.copy_done) commit <= 1'b0;
    end
  end

  assign stat.commit    = commit;
  assign stat.copy_done = (copy_idx + 8'd1 >= copy_len);

  // Staging read is registered, so the buffer write happens in the cycle after the copy command.
  always_ff @(posedge clk) begin
    stage_q <= stage_mem[copy_idx];
    wr_addr <= copy_off + BW'(copy_idx);
  end
  always_ff @(posedge clk) begin
    if (rst) copy_wr <= 1'b0;
    else     copy_wr <= cmd.copy;
  end

  always_ff @(posedge clk) begin
    if (copy_wr) frame_mem[wr_addr] <= stage_q;
    rd_q <= frame_mem[read_address];
  end

  logic [7:0] rd_hold;
  always_ff @(posedge clk) begin
    if (rst) rd_valid <= 1'b0;
    else     rd_valid <= cmd.read;
    if (rd_valid) rd_hold <= rd_q;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish || cmd.emit_read;
    end
    status <= frd_pkg::ST_PENDING; frame_stream <= '0; frame_sequence <= '0;
    frame_length <= '0; read_data <= '0;
    if (cmd.emit_read) begin
      status    <= frd_pkg::ST_READ;
      read_data <= rd_valid ? rd_q : rd_hold;
    end else if (cmd.finish) begin
      status <= verdict_q;
      if (verdict_q == frd_pkg::ST_COMPLETE) begin
        frame_stream <= cur_stream; frame_sequence <= cur_seq; frame_length <= alen;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) cmd.copy |-> commit)
    else $error("copy without a committed packet");
  assert property (@(posedge clk) disable iff (rst) copy_wr |=> !cmd.check)
    else $error("check overlapped a copy");
  assert property (@(posedge clk) disable iff (rst) cmd.check |=> pcount == '0)
    else $error("byte count not cleared after the final byte");

endmodule

// ----- design/fragment_reassembly_deframer_core.sv -----
// ----------------------------------------------------------------------------
// fragment_reassembly_deframer_core: packet deframer and frame reassembler
//
//   channel  direction  handshake               payload
//   command  in         start, busy             opcode, data_byte, last_byte,
//                                               read_address
//   config   in         cfg_valid, cfg_ready    cfg_index, cfg_data
//   result   out        done (one cycle)        status, frame_stream,
//                                               frame_sequence, frame_length,
//                                               read_data
//
// A packet byte without the last mark leaves the controller idle for the next
// word. A final byte steps through the check, the payload copy when a payload
// is committed, one byte at a time through the single write port of the frame
// buffer, and the verdict step; its word is registered behind that step. A
// read issues the registered buffer read, then the emit step, and its word is
// registered behind it. Reset is synchronous; both memories need no clearing.
// The receiver cannot stall, so results leave on done.
// ----------------------------------------------------------------------------
module fragment_reassembly_deframer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        opcode,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic [10:0] read_address,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        done,
  output logic [2:0]  status,
  output logic [7:0]  frame_stream,
  output logic [15:0] frame_sequence,
  output logic [11:0] frame_length,
  output logic [7:0]  read_data
);

  frd_pkg::frd_cmd_t  cmd;
  frd_pkg::frd_stat_t stat;
  logic [7:0]  max_radio_payload, expected_version, expected_packet_type;
  logic [15:0] expected_magic;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_radio_payload <= 8'd255; expected_magic <= '0;
      expected_version <= '0; expected_packet_type <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        frd_pkg::REG_MAX_PAYLOAD: max_radio_payload    <= cfg_data[7:0];
        frd_pkg::REG_MAGIC:       expected_magic       <= cfg_data;
        frd_pkg::REG_VERSION:     expected_version     <= cfg_data[7:0];
        frd_pkg::REG_TYPE:        expected_packet_type <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  frd_ctrl u_ctrl (
    .clk, .rst, .start, .opcode, .last_byte, .stat, .busy, .cmd
  );

  frd_datapath u_dp (
    .clk, .rst, .cmd, .stat, .data_byte, .read_address, .max_radio_payload,
    .expected_magic, .expected_version, .expected_packet_type, .done, .status,
    .frame_stream, .frame_sequence, .frame_length, .read_data
  );

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for fragment_reassembly_deframer_core
// Drives packet words and frame buffer reads through the command port,
// predicts every verdict and read word in a scoreboard, and checks each
// result word field by field under random sender gaps and register settings.
// ----------------------------------------------------------------------------
module testbench;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    logic [2:0]  status;
    logic [7:0]  stream;
    logic [15:0] seq;
    logic [11:0] length;
    logic [7:0]  rdata;
  } verdict_t;

  typedef enum int {
    F_NONE, F_MAGIC, F_VERSION, F_TYPE, F_SUM, F_CRC, F_PLEN, F_CNT0, F_CNTBIG, F_IDX
  } fault_t;

  class deframer_scoreboard;
    logic [7:0]  max_payload;
    logic [15:0] magic;
    logic [7:0]  version;
    logic [7:0]  ptype;
    logic [7:0]  hdr [11];
    logic [7:0]  stage [255];
    int          byte_count;
    logic [15:0] crc;
    logic [15:0] tail;
    bit          active;
    logic [7:0]  cur_stream;
    logic [15:0] cur_seq;
    logic [7:0]  cur_count;
    logic [15:0] mask;
    int          asm_len;
    logic [7:0]  frame_mem [frd_pkg::FRAME_BUF_BYTES];
    bit          written [frd_pkg::FRAME_BUF_BYTES];
    int          written_addr[$];
    verdict_t    pending[$];
    int          errors;

    function new();
      max_payload = 8'd255;
      magic = 16'h0;
      version = 8'h0;
      ptype = 8'h0;
      foreach (hdr[i]) hdr[i] = 8'h0;
      byte_count = 0;
      crc = 16'hFFFF;
      tail = 16'h0;
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      active = 0;
      cur_stream = 0;
      cur_seq = 0;
      cur_count = 0;
      mask = 0;
      asm_len = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] v);
      case (idx)
        frd_pkg::REG_MAX_PAYLOAD: max_payload = v[7:0];
        frd_pkg::REG_MAGIC:       magic = v;
        frd_pkg::REG_VERSION:     version = v[7:0];
        frd_pkg::REG_TYPE:        ptype = v[7:0];
        default: ;
      endcase
    endfunction

    function int fragment_limit();
      if (max_payload <= frd_pkg::OVERHEAD) return 0;
      return int'(max_payload) - frd_pkg::OVERHEAD;
    endfunction

    function logic [15:0] crc16_update(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) r = r[15] ? ({r[14:0], 1'b0} ^ 16'h1021) : {r[14:0], 1'b0};
      return r;
    endfunction

    function logic [2:0] judge_packet(int len, logic [15:0] c, logic [15:0] t);
      int idx, cnt, plen, off, lim;
      logic [7:0] sum;
      logic [16:0] full;
      if (len < frd_pkg::OVERHEAD + 1 || len > frd_pkg::MAX_PACKET_BYTES)
        return frd_pkg::ST_SIZE;
      if ({hdr[0], hdr[1]} != magic || hdr[2] != version || hdr[3] != ptype)
        return frd_pkg::ST_IDENTITY;
      idx = hdr[7];
      cnt = hdr[8];
      plen = hdr[9];
      if (cnt == 0 || cnt > frd_pkg::MAX_FRAGMENTS || idx >= cnt) return frd_pkg::ST_SIZE;
      if (plen != len - frd_pkg::OVERHEAD) return frd_pkg::ST_SIZE;
      sum = 0;
      for (int i = 0; i < 10; i++) sum += hdr[i];
      if (sum != hdr[10] || c != t) return frd_pkg::ST_CHECKSUM;
      if (!active || cur_stream != hdr[4] || cur_seq != {hdr[5], hdr[6]} ||
          cur_count != cnt[7:0]) begin
        clear_frame();
        active = 1;
        cur_stream = hdr[4];
        cur_seq = {hdr[5], hdr[6]};
        cur_count = cnt[7:0];
      end
      if (mask[idx]) return frd_pkg::ST_DUPLICATE;
      lim = fragment_limit();
      off = idx * lim;
      if (off + plen > frd_pkg::FRAME_BUF_BYTES) begin
        clear_frame();
        return frd_pkg::ST_SIZE;
      end
      for (int i = 0; i < plen; i++) begin
        frame_mem[off + i] = stage[i];
        if (!written[off + i]) begin
          written[off + i] = 1;
          written_addr.push_back(off + i);
        end
      end
      mask[idx] = 1'b1;
      if (off + plen > asm_len) asm_len = off + plen;
      full = (17'd1 << cnt) - 17'd1;
      if ((mask & full[15:0]) != full[15:0]) return frd_pkg::ST_PENDING;
      active = 0;
      return frd_pkg::ST_COMPLETE;
    endfunction

    // Notes one accepted command word and queues the result it causes.
    function void note_item(logic op, logic [7:0] b, logic last, logic [10:0] addr);
      verdict_t v;
      int len;
      logic [15:0] c, t;
      v = '{default: '0};
      if (op == frd_pkg::OP_READ) begin
        v.status = frd_pkg::ST_READ;
        v.rdata = frame_mem[addr];
        pending.push_back(v);
        return;
      end
      if (byte_count < frd_pkg::HDR_LEN) hdr[byte_count] = b;
      else if (byte_count - frd_pkg::HDR_LEN < 255) stage[byte_count - frd_pkg::HDR_LEN] = b;
      if (byte_count >= 2) crc = crc16_update(crc, tail[15:8]);
      tail = {tail[7:0], b};
      if (byte_count < frd_pkg::CNT_SAT) byte_count++;
      if (!last) return;
      len = byte_count;
      c = crc;
      t = tail;
      byte_count = 0;
      crc = 16'hFFFF;
      tail = 16'h0;
      v.status = judge_packet(len, c, t);
      if (v.status == frd_pkg::ST_COMPLETE) begin
        v.stream = cur_stream;
        v.seq = cur_seq;
        v.length = asm_len[11:0];
      end
      pending.push_back(v);
    endfunction

    function void check_result(logic [2:0] st, logic [7:0] sid, logic [15:0] sq,
                               logic [11:0] flen, logic [7:0] rd);
      verdict_t e;
      if (pending.size() == 0) begin
        $error("unexpected result word, status %0d", st);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st); errors++;
      end
      if (sid !== e.stream) begin
        $error("frame_stream: expected %0d, got %0d", e.stream, sid); errors++;
      end
      if (sq !== e.seq) begin
        $error("frame_sequence: expected %0d, got %0d", e.seq, sq); errors++;
      end
      if (flen !== e.length) begin
        $error("frame_length: expected %0d, got %0d", e.length, flen); errors++;
      end
      if (rd !== e.rdata) begin
        $error("read_data: expected %0d, got %0d", e.rdata, rd); errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        opcode;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [10:0] read_address;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        done;
  logic [2:0]  status;
  logic [7:0]  frame_stream;
  logic [15:0] frame_sequence;
  logic [11:0] frame_length;
  logic [7:0]  read_data;

  deframer_scoreboard sb;
  int  words_sent;
  int  idle_cycles;
  bit  no_gaps;

  fragment_reassembly_deframer_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .data_byte(data_byte), .last_byte(last_byte), .read_address(read_address),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .status(status), .frame_stream(frame_stream),
    .frame_sequence(frame_sequence), .frame_length(frame_length), .read_data(read_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done)
      sb.check_result(status, frame_stream, frame_sequence, frame_length, read_data);
  end

  // Watchdog: any accepted word or result restarts the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 3000) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  function int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_word(logic op, logic [7:0] b, logic last, logic [10:0] addr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    data_byte <= b;
    last_byte <= last;
    read_address <= addr;
    do @(posedge clk); while (busy);
    sb.note_item(op, b, last, addr);
    words_sent++;
  endtask

  task automatic send_packet(byte_q_t pk);
    foreach (pk[i]) send_word(frd_pkg::OP_BYTE, pk[i], i == pk.size() - 1, 11'($urandom));
  endtask

  task automatic read_back();
    if (sb.written_addr.size() == 0) return;
    send_word(frd_pkg::OP_READ, 8'($urandom), 1'($urandom),
              11'(sb.written_addr[$urandom_range(sb.written_addr.size() - 1)]));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, v);
  endtask

  task automatic configure(logic [7:0] mp, logic [15:0] mg, logic [7:0] ver, logic [7:0] pt);
    wait_drained();
    write_reg(frd_pkg::REG_MAX_PAYLOAD, {8'h0, mp});
    write_reg(frd_pkg::REG_MAGIC, mg);
    write_reg(frd_pkg::REG_VERSION, {8'h0, ver});
    write_reg(frd_pkg::REG_TYPE, {8'h0, pt});
    cfg_valid <= 1'b0;
  endtask

  task automatic make_packet(logic [7:0] sid, logic [15:0] sq, int idx, int cnt, int plen,
                             fault_t f, output byte_q_t pk);
    logic [7:0]  sum;
    logic [15:0] c;
    pk = {};
    pk.push_back(sb.magic[15:8] ^ ((f == F_MAGIC) ? 8'h01 << $urandom_range(7) : 8'h00));
    pk.push_back(sb.magic[7:0]);
    pk.push_back(sb.version ^ ((f == F_VERSION) ? 8'h80 : 8'h00));
    pk.push_back(sb.ptype ^ ((f == F_TYPE) ? 8'h01 : 8'h00));
    pk.push_back(sid);
    pk.push_back(sq[15:8]);
    pk.push_back(sq[7:0]);
    pk.push_back((f == F_IDX) ? 8'(cnt + $urandom_range(0, 3)) : 8'(idx));
    pk.push_back((f == F_CNT0) ? 8'd0 : (f == F_CNTBIG) ? 8'($urandom_range(17, 255)) : 8'(cnt));
    pk.push_back(8'(plen + ((f == F_PLEN) ? 1 : 0)));
    sum = 0;
    for (int i = 0; i < 10; i++) sum += pk[i];
    pk.push_back(sum ^ ((f == F_SUM) ? 8'h10 : 8'h00));
    for (int i = 0; i < plen; i++) pk.push_back(8'($urandom));
    c = 16'hFFFF;
    foreach (pk[i]) c = sb.crc16_update(c, pk[i]);
    if (f == F_CRC) c ^= 16'h0001 << $urandom_range(15);
    pk.push_back(c[15:8]);
    pk.push_back(c[7:0]);
  endtask

  task automatic directed_part();
    byte_q_t pk;
    make_packet(8'h00, 16'h0000, 0, 1, 1, F_NONE, pk); send_packet(pk);
    make_packet(8'hFF, 16'hFFFF, 0, 2, 5, F_NONE, pk); send_packet(pk);
    send_packet(pk); // duplicate fragment
    make_packet(8'hFF, 16'hFFFF, 1, 2, 242, F_NONE, pk); send_packet(pk);
    for (int f = F_MAGIC; f <= F_IDX; f++) begin
      make_packet(8'h12, 16'h3456, 0, 3, 4, fault_t'(f), pk);
      send_packet(pk);
    end
    // Fragment whose offset runs past the frame buffer.
    make_packet(8'h21, 16'h0001, 15, 16, 10, F_NONE, pk); send_packet(pk);
    // Fragment that ends exactly at the last buffer byte.
    make_packet(8'h22, 16'h0002, 8, 9, 112, F_NONE, pk); send_packet(pk);
    // Packet one byte too short, then one long enough to saturate the count.
    pk = {};
    repeat (13) pk.push_back(8'($urandom));
    send_packet(pk);
    pk = {};
    repeat (520) pk.push_back(8'($urandom));
    send_packet(pk);
    send_word(frd_pkg::OP_READ, 8'h00, 1'b0, 11'd2047);
    send_word(frd_pkg::OP_READ, 8'hFF, 1'b1, 11'd0);
  endtask

  task automatic random_frames(int goal);
    byte_q_t pk;
    int order[$];
    int cnt, lim, plen, tmp, j, r;
    logic [7:0]  sid;
    logic [15:0] sq;
    fault_t f;
    goal += words_sent;
    while (words_sent < goal) begin
      no_gaps = ($urandom_range(99) < 20);
      sid = 8'($urandom_range(0, 3));
      sq = 16'($urandom);
      cnt = ($urandom_range(99) < 70) ? $urandom_range(1, 4) : $urandom_range(1, 16);
      lim = sb.fragment_limit();
      order = {};
      for (int i = 0; i < cnt; i++) order.push_back(i);
      for (int i = cnt - 1; i > 0; i--) begin
        j = $urandom_range(i);
        tmp = order[i]; order[i] = order[j]; order[j] = tmp;
      end
      if (cnt > 1 && $urandom_range(99) < 10) void'(order.pop_back());
      foreach (order[k]) begin
        r = $urandom_range(99);
        if (r < 3) plen = $urandom_range(1, 242);
        else if (lim > 0 && r < 80) plen = $urandom_range(1, (lim < 30) ? lim : 30);
        else plen = $urandom_range(1, 20);
        f = ($urandom_range(99) < 88) ? F_NONE : fault_t'($urandom_range(F_MAGIC, F_IDX));
        make_packet(sid, sq, order[k], cnt, plen, f, pk);
        send_packet(pk);
        if ($urandom_range(99) < 8) send_packet(pk);
        if ($urandom_range(99) < 15) repeat ($urandom_range(1, 3)) read_back();
        if ($urandom_range(99) < 5) begin
          pk = {};
          repeat ($urandom_range(1, 15)) pk.push_back(8'($urandom));
          send_packet(pk);
        end
      end
      if ($urandom_range(99) < 3) wait_drained();
    end
    no_gaps = 0;
  endtask

  initial begin
    sb = new();
    words_sent = 0;
    no_gaps = 0;
    rst = 1'b1;
    start = 1'b0;
    opcode = frd_pkg::OP_BYTE;
    data_byte = 8'h00;
    last_byte = 1'b0;
    read_address = 11'h0;
    cfg_valid = 1'b0;
    cfg_index = frd_pkg::REG_MAX_PAYLOAD;
    cfg_data = 16'h0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    configure(8'd255, 16'hA5C3, 8'd1, 8'd2);
    directed_part();
    random_frames(60);
    configure(8'd1, 16'hFFFF, 8'd255, 8'd255);
    random_frames(50);
    configure(8'd13, 16'h0000, 8'd0, 8'd0);
    random_frames(50);
    configure(8'd14, 16'($urandom), 8'($urandom), 8'($urandom));
    random_frames(60);
    configure(8'($urandom_range(20, 60)), 16'($urandom), 8'($urandom), 8'($urandom));
    random_frames(70);
    configure(8'($urandom_range(1, 255)), 16'($urandom), 8'($urandom), 8'($urandom));
    random_frames(60);
    wait_drained();
    if (sb.errors == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule
